>>> hdl/mmu_pkg.sv
// ----------------------------------------------------------------------------
// mmu_pkg: shared types and codes of the matrix multiply unit
// Function codes, register indexes, field widths and the command and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package mmu_pkg;

  localparam int IDX_W   = 3;
  localparam int DIM_W   = 4;
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 32;
  localparam int SUM_W   = 36;
  localparam int FUNC_W  = 2;
  localparam int CFG_A_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  localparam logic [CFG_A_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_COLS_B    = 2'd2;

  typedef struct packed {
    logic             we_a;
    logic             we_b;
    logic             clear_acc;
    logic             issue;
    logic [IDX_W-1:0] rd_i;
    logic [IDX_W-1:0] rd_j;
    logic [IDX_W-1:0] rd_k;
  } mmu_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } mmu_status_t;

endpackage

>>> hdl/mmu_datapath.sv
// ----------------------------------------------------------------------------
// mmu_datapath: operand stores and multiply-accumulate pipeline
// Holds the A and B stores, reads one operand pair per issued step, multiplies
// them in a registered stage and adds the product into the accumulator.
// ----------------------------------------------------------------------------
module mmu_datapath #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mmu_pkg::mmu_cmd_t                   cmd,
  input  logic [mmu_pkg::IDX_W-1:0]           in_row,
  input  logic [mmu_pkg::IDX_W-1:0]           in_col,
  input  logic [mmu_pkg::ELEM_W-1:0]          in_value,
  output mmu_pkg::mmu_status_t                status,
  output logic signed [mmu_pkg::SUM_W-1:0]    sum
);
  import mmu_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ELEM_W-1:0]        mem_a [DEPTH];
  logic [ELEM_W-1:0]        mem_b [DEPTH];
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr_a;
  logic [AW-1:0]            rd_addr_b;
  logic                     in_range;
  logic signed [ELEM_W-1:0] rd_a_r;
  logic signed [ELEM_W-1:0] rd_b_r;
  logic                     rd_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     mul_vld_r;
  logic signed [SUM_W-1:0]  acc_r;

  assign in_range  = ({1'b0, in_row} < DIM_W'(MAX_DIM)) && ({1'b0, in_col} < DIM_W'(MAX_DIM));
  assign wr_addr   = AW'(int'(in_row) * MAX_DIM + int'(in_col));
  assign rd_addr_a = AW'(int'(cmd.rd_i) * MAX_DIM + int'(cmd.rd_k));
  assign rd_addr_b = AW'(int'(cmd.rd_k) * MAX_DIM + int'(cmd.rd_j));

  always_ff @(posedge clk) begin
    if (cmd.we_a && in_range) begin
      mem_a[wr_addr] <= in_value;
    end
    if (cmd.we_b && in_range) begin
      mem_b[wr_addr] <= in_value;
    end
    if (cmd.issue) begin
      rd_a_r <= mem_a[rd_addr_a];
      rd_b_r <= mem_b[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= rd_a_r * rd_b_r;
    if (cmd.clear_acc) begin
      acc_r <= '0;
    end else if (mul_vld_r) begin
      acc_r <= acc_r + SUM_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.issue;
      mul_vld_r <= rd_vld_r;
    end
  end

  assign status.pipe_busy = rd_vld_r | mul_vld_r;
  assign sum              = acc_r;

endmodule

>>> hdl/mmu_ctrl.sv
// ----------------------------------------------------------------------------
// mmu_ctrl: sequencer of the matrix multiply unit
// Decodes input beats, holds the dimension registers and walks the result
// elements and the inner index, handing out one result beat per element.
// ----------------------------------------------------------------------------
module mmu_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mmu_pkg::FUNC_W-1:0]        in_func,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mmu_pkg::IDX_W-1:0]         out_row,
  output logic [mmu_pkg::IDX_W-1:0]         out_col,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [mmu_pkg::CFG_A_W-1:0]       cfg_addr,
  input  logic [mmu_pkg::DIM_W-1:0]         cfg_wdata,
  output mmu_pkg::mmu_cmd_t                 cmd,
  input  mmu_pkg::mmu_status_t              status
);
  import mmu_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [DIM_W-1:0] nr_r, nk_r, nc_r;
  logic [DIM_W-1:0] cfg_clamped;
  logic             in_fire;
  logic             out_fire;
  logic             j_end;
  logic             k_end;

  assign in_tready   = (state_r == ST_IDLE);
  assign out_tvalid  = (state_r == ST_OUT);
  assign in_fire     = in_tvalid & in_tready;
  assign out_fire    = out_tvalid & out_tready;
  assign j_end       = ({1'b0, j_r} + DIM_W'(1)) == nc_r;
  assign k_end       = ({1'b0, k_r} + DIM_W'(1)) == nk_r;
  assign out_last    = (({1'b0, i_r} + DIM_W'(1)) == nr_r) && j_end;
  assign out_row     = i_r;
  assign out_col     = j_r;
  assign cfg_clamped = (cfg_wdata > DIM_MAX) ? DIM_MAX : cfg_wdata;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    cmd.we_a      = in_fire && (in_func == FUNC_LOAD_A);
    cmd.we_b      = in_fire && (in_func == FUNC_LOAD_B);
    cmd.clear_acc = 1'b0;
    cmd.issue     = 1'b0;
    cmd.rd_i      = i_r;
    cmd.rd_j      = j_r;
    cmd.rd_k      = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_func == FUNC_COMPUTE) && (nr_r != '0) && (nc_r != '0)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.clear_acc = 1'b1;
        k_nxt         = '0;
        state_nxt     = (nk_r == '0) ? ST_DRAIN : ST_MAC;
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        if (k_end) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          if (out_last) begin
            state_nxt = ST_IDLE;
          end else begin
            if (j_end) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
            state_nxt = ST_START;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      nr_r    <= DIM_MAX;
      nk_r    <= DIM_MAX;
      nc_r    <= DIM_MAX;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_ROWS_A:    nr_r <= cfg_clamped;
          CFG_INNER_DIM: nk_r <= cfg_clamped;
          CFG_COLS_B:    nc_r <= cfg_clamped;
          default: begin
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_out_after_drain : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !status.pipe_busy)
    else $error("Result offered while products are still in flight.");

  a_last_ends_run : assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last) |=> in_tready)
    else $error("Sequencer did not return to idle after the last beat.");

  a_issue_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> ({1'b0, k_r} < nk_r))
    else $error("Inner index issued beyond the inner dimension.");

  a_result_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (({1'b0, i_r} < nr_r) && ({1'b0, j_r} < nc_r)))
    else $error("Result element outside the result matrix.");
`endif

endmodule

>>> hdl/matrix_multiply_unit.sv
// ----------------------------------------------------------------------------
// matrix_multiply_unit: signed Q8.8 dense matrix multiply, up to 8 by 8
// Loads elements of A and B into on-chip stores and, on a compute beat,
// streams every element of C = A x B in row-major order as Q20.16 sums.
// ----------------------------------------------------------------------------
// Load beats are taken one per cycle while no run is in progress. A compute
// beat starts a run in which each result element passes through these steps:
// the accumulator is cleared, one store read is made per inner index, the
// operand register, the multiplier and the accumulator are drained, and then
// the result beat is offered. The single read port of each operand store
// allows one operand pair to be read per inner index. No input beat is taken
// until the last result beat of the run has been taken. Dimensions above
// MAX_DIM act as MAX_DIM, and a zero row or column count makes a compute
// produce no beats.
module matrix_multiply_unit #(
  parameter int MAX_DIM = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // row[2:0], col[5:3], value[21:6]
  input  logic [mmu_pkg::FUNC_W-1:0]      in_tuser,   // func[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata,  // out_row[2:0], out_col[5:3], sum[41:6]
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [mmu_pkg::CFG_A_W-1:0]     cfg_addr,
  input  logic [mmu_pkg::DIM_W-1:0]       cfg_wdata
);
  import mmu_pkg::*;

  mmu_cmd_t                 cmd;
  mmu_status_t              status;
  logic [IDX_W-1:0]         res_row;
  logic [IDX_W-1:0]         res_col;
  logic signed [SUM_W-1:0]  res_sum;

  mmu_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_row    (res_row),
    .out_col    (res_col),
    .out_last   (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .status     (status)
  );

  mmu_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_row   (in_tdata[2:0]),
    .in_col   (in_tdata[5:3]),
    .in_value (in_tdata[21:6]),
    .status   (status),
    .sum      (res_sum)
  );

  assign out_tdata = {6'b0, res_sum, res_col, res_row};

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream-level check of matrix_multiply_unit
// Loads elements of A and B, starts products under a range of dimension
// settings and compares every result beat with a behavioral model of the
// Q8.8 multiply and Q20.16 accumulate, with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import mmu_pkg::*;

  localparam int MAX_DIM = 8;
  localparam logic [FUNC_W-1:0]  FUNC_SPARE = 2'd3;
  localparam logic [CFG_A_W-1:0] CFG_SPARE  = 2'd3;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [35:0] sum;
    logic        last;
  } c_elem_t;

  typedef enum logic {ROW_CFG, ROW_BEAT} step_kind_t;

  typedef struct {
    step_kind_t          kind;
    logic [CFG_A_W-1:0]  reg_idx;
    logic [DIM_W-1:0]    reg_val;
    logic [FUNC_W-1:0]   func;
    logic [2:0]          row;
    logic [2:0]          col;
    logic [15:0]         value;
    bit                  typed;
    logic [35:0]         typed_sum;
  } step_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [23:0]        in_tdata = '0;   // row[2:0], col[5:3], value[21:6]
  logic [FUNC_W-1:0]  in_tuser = FUNC_LOAD_A;  // func[1:0]
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [47:0]        out_tdata;       // out_row[2:0], out_col[5:3], sum[41:6]
  logic               out_tlast;
  logic               cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = CFG_ROWS_A;
  logic [DIM_W-1:0]   cfg_wdata = '0;

  // Model state, updated at the clock edge on accepted beats and writes.
  logic signed [15:0] a_elems [MAX_DIM*MAX_DIM];
  logic signed [15:0] b_elems [MAX_DIM*MAX_DIM];
  logic [DIM_W-1:0]   n_rows = 4'd8;
  logic [DIM_W-1:0]   n_inner = 4'd8;
  logic [DIM_W-1:0]   n_cols = 4'd8;
  c_elem_t            c_expected[$];

  // Stimulus side bookkeeping.
  bit                 a_loaded [MAX_DIM*MAX_DIM];
  bit                 b_loaded [MAX_DIM*MAX_DIM];
  logic [DIM_W-1:0]   plan_rows, plan_inner, plan_cols;
  bit                 cur_typed = 1'b0;
  logic [35:0]        cur_typed_sum = '0;
  bit                 calm = 1'b0;
  int                 items_sent = 0;
  step_t              directed[$];

  int in_beats = 0, product_runs = 0, result_beats = 0, cfg_writes = 0, errors = 0;

  matrix_multiply_unit #(.MAX_DIM(MAX_DIM)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("[matrix_multiply_unit] ERROR");
    $finish;
  end

  function automatic int clamp_dim(input logic [DIM_W-1:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  task automatic product_matrix();
    int      nr, nk, nc;
    longint  acc;
    c_elem_t e;
    nr = clamp_dim(n_rows);
    nk = clamp_dim(n_inner);
    nc = clamp_dim(n_cols);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nk; k++) begin
          acc += longint'(a_elems[i*MAX_DIM+k]) * longint'(b_elems[k*MAX_DIM+j]);
        end
        e.row  = 3'(i);
        e.col  = 3'(j);
        e.sum  = acc[35:0];
        e.last = (i == nr - 1) && (j == nc - 1);
        c_expected.push_back(e);
      end
    end
  endtask

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 16);
  end

  // Result beats are checked before the input beat of the same edge is
  // applied to the model, so the order of processes at the edge does not
  // matter.
  always @(posedge clk) begin
    c_elem_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        result_beats++;
        got = {out_tdata[2:0], out_tdata[5:3], out_tdata[41:6], out_tlast};
        if (c_expected.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("Unexpected result beat: row %0d col %0d sum %0d last %0d",
                     got.row, got.col, $signed(got.sum), got.last);
          end
        end else begin
          want = c_expected.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10) begin
              $display("Result %0d: expected row %0d col %0d sum %0d last %0d,",
                       result_beats, want.row, want.col, $signed(want.sum), want.last);
              $display("  got row %0d col %0d sum %0d last %0d",
                       got.row, got.col, $signed(got.sum), got.last);
            end
          end
        end
      end
      if (cfg_we) begin
        cfg_writes++;
        case (cfg_addr)
          CFG_ROWS_A:    n_rows = cfg_wdata;
          CFG_INNER_DIM: n_inner = cfg_wdata;
          CFG_COLS_B:    n_cols = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        in_beats++;
        case (in_tuser)
          FUNC_LOAD_A: a_elems[{in_tdata[2:0], in_tdata[5:3]}] = in_tdata[21:6];
          FUNC_LOAD_B: b_elems[{in_tdata[2:0], in_tdata[5:3]}] = in_tdata[21:6];
          FUNC_COMPUTE: begin
            product_runs++;
            if (cur_typed) begin
              c_expected.push_back({3'd0, 3'd0, cur_typed_sum, 1'b1});
            end else begin
              product_matrix();
            end
          end
          default: ;
        endcase
      end
    end
  end

  task automatic send_beat(input logic [FUNC_W-1:0] func, input logic [2:0] row,
                           input logic [2:0] col, input logic [15:0] value,
                           input bit typed, input logic [35:0] typed_sum);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {2'b00, value, col, row};
    cur_typed     = typed;
    cur_typed_sum = typed_sum;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    if (func == FUNC_LOAD_A) a_loaded[{row, col}] = 1'b1;
    if (func == FUNC_LOAD_B) b_loaded[{row, col}] = 1'b1;
    if (func != FUNC_SPARE) items_sent++;
  endtask

  // Drain all results, then give a zero-sized product time to finish.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (c_expected.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_A_W-1:0] addr, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] elem_value();
    case ($urandom_range(19))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 4'd0;
    if (r < 75) return 4'($urandom_range(1, 4));
    if (r < 90) return 4'($urandom_range(5, 8));
    return 4'($urandom_range(9, 15));
  endfunction

  task automatic noise();
    int r;
    r = $urandom_range(99);
    if (r < 4) begin
      send_beat(FUNC_SPARE, 3'($urandom), 3'($urandom), 16'($urandom), 1'b0, '0);
    end else if (r < 10) begin
      send_beat($urandom_range(1) ? FUNC_LOAD_A : FUNC_LOAD_B, 3'($urandom),
                3'($urandom), elem_value(), 1'b0, '0);
    end
  endtask

  task automatic run_phase(input bit new_dims, input bit widest);
    int nr, nk, nc;
    if (new_dims) begin
      settle();
      plan_rows  = widest ? 4'd8 : pick_dim();
      plan_inner = widest ? 4'd15 : pick_dim();
      plan_cols  = widest ? 4'd8 : pick_dim();
      cfg_write(CFG_ROWS_A, plan_rows);
      cfg_write(CFG_INNER_DIM, plan_inner);
      cfg_write(CFG_COLS_B, plan_cols);
      if ($urandom_range(9) == 0) cfg_write(CFG_SPARE, 4'($urandom));
    end
    nr = clamp_dim(plan_rows);
    nk = clamp_dim(plan_inner);
    nc = clamp_dim(plan_cols);
    for (int i = 0; i < nr; i++) begin
      for (int k = 0; k < nk; k++) begin
        if (!a_loaded[i*MAX_DIM+k] || $urandom_range(1)) begin
          noise();
          send_beat(FUNC_LOAD_A, 3'(i), 3'(k), elem_value(), 1'b0, '0);
        end
      end
    end
    for (int k = 0; k < nk; k++) begin
      for (int j = 0; j < nc; j++) begin
        if (!b_loaded[k*MAX_DIM+j] || $urandom_range(1)) begin
          noise();
          send_beat(FUNC_LOAD_B, 3'(k), 3'(j), elem_value(), 1'b0, '0);
        end
      end
    end
    if ($urandom_range(99) < 15) settle();
    send_beat(FUNC_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom), 1'b0, '0);
    if ($urandom_range(99) < 20) begin
      send_beat(FUNC_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom), 1'b0, '0);
    end
  endtask

  function automatic void tab_cfg(input logic [CFG_A_W-1:0] idx, input logic [DIM_W-1:0] val);
    step_t s;
    s = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, func: FUNC_SPARE, row: 3'd0,
          col: 3'd0, value: 16'd0, typed: 1'b0, typed_sum: '0};
    directed.push_back(s);
  endfunction

  function automatic void tab_beat(input logic [FUNC_W-1:0] func, input logic [2:0] row,
                                   input logic [2:0] col, input logic [15:0] value,
                                   input bit typed, input logic [35:0] typed_sum);
    step_t s;
    s = '{kind: ROW_BEAT, reg_idx: CFG_SPARE, reg_val: 4'd0, func: func, row: row,
          col: col, value: value, typed: typed, typed_sum: typed_sum};
    directed.push_back(s);
  endfunction

  initial begin
    step_t s;
    int    phase_no;
    for (int n = 0; n < MAX_DIM * MAX_DIM; n++) begin
      a_elems[n] = '0;
      b_elems[n] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // A single element product at the extremes of Q8.8.
    tab_cfg(CFG_ROWS_A, 4'd1);
    tab_cfg(CFG_INNER_DIM, 4'd1);
    tab_cfg(CFG_COLS_B, 4'd1);
    tab_beat(FUNC_LOAD_A, 3'd0, 3'd0, 16'h7FFF, 1'b0, '0);
    tab_beat(FUNC_LOAD_B, 3'd0, 3'd0, 16'h7FFF, 1'b0, '0);
    tab_beat(FUNC_COMPUTE, 3'd7, 3'd7, 16'hFFFF, 1'b1, 36'sd1073676289);
    tab_beat(FUNC_LOAD_A, 3'd0, 3'd0, 16'h8000, 1'b0, '0);
    tab_beat(FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, -36'sd1073709056);
    tab_beat(FUNC_LOAD_B, 3'd0, 3'd0, 16'h8000, 1'b0, '0);
    tab_beat(FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 36'sd1073741824);
    // The unused function code must leave the stores alone.
    tab_beat(FUNC_SPARE, 3'd0, 3'd0, 16'h0001, 1'b0, '0);
    tab_beat(FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 36'sd1073741824);
    // An empty inner dimension gives zero sums.
    tab_cfg(CFG_INNER_DIM, 4'd0);
    tab_beat(FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 36'sd0);
    // Zero rows or zero columns give no result beats at all.
    tab_cfg(CFG_INNER_DIM, 4'd1);
    tab_cfg(CFG_ROWS_A, 4'd0);
    tab_beat(FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b0, '0);
    tab_cfg(CFG_ROWS_A, 4'd1);
    tab_cfg(CFG_COLS_B, 4'd0);
    tab_beat(FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b0, '0);
    // A row count above the maximum acts as the maximum.
    tab_cfg(CFG_COLS_B, 4'd1);
    tab_cfg(CFG_ROWS_A, 4'd15);
    tab_beat(FUNC_LOAD_A, 3'd1, 3'd0, 16'hFFFF, 1'b0, '0);
    tab_beat(FUNC_LOAD_A, 3'd2, 3'd0, 16'h0001, 1'b0, '0);
    tab_beat(FUNC_LOAD_A, 3'd3, 3'd0, 16'h7FFF, 1'b0, '0);
    tab_beat(FUNC_LOAD_A, 3'd4, 3'd0, 16'h8000, 1'b0, '0);
    tab_beat(FUNC_LOAD_A, 3'd5, 3'd0, 16'h0100, 1'b0, '0);
    tab_beat(FUNC_LOAD_A, 3'd6, 3'd0, 16'hFF00, 1'b0, '0);
    tab_beat(FUNC_LOAD_A, 3'd7, 3'd0, 16'h5A5A, 1'b0, '0);
    tab_beat(FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b0, '0);
    // A write to the unused register index changes nothing.
    tab_cfg(CFG_SPARE, 4'd15);
    tab_beat(FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b0, '0);

    foreach (directed[n]) begin
      s = directed[n];
      if (s.kind == ROW_CFG) begin
        settle();
        cfg_write(s.reg_idx, s.reg_val);
      end else begin
        send_beat(s.func, s.row, s.col, s.value, s.typed, s.typed_sum);
      end
    end

    phase_no = 0;
    while (items_sent < 430) begin
      calm = (phase_no >= 8) && (phase_no < 14);
      run_phase((phase_no == 0) || ($urandom_range(99) < 60), phase_no == 0);
      phase_no++;
    end
    calm = 1'b0;

    settle();
    repeat (32) @(posedge clk);
    $display("Covered %0d input beats, %0d products and %0d result beats,",
             in_beats, product_runs, result_beats);
    $display("with %0d register writes spanning empty, small, full and oversized dimensions.",
             cfg_writes);
    if (errors == 0) begin
      $display("[matrix_multiply_unit] OK");
    end else begin
      $display("%0d result errors in total.", errors);
      $display("[matrix_multiply_unit] ERROR");
    end
    $finish;
  end

endmodule
